// ===== src/swpm_pkg.sv =====
// Package: widths, register indexes and helper types for the pattern matcher.
package swpm_pkg;
  localparam int unsigned PatternLenDefault = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned TotalW = 40;
  localparam int unsigned PosW = 32;
  localparam int unsigned CmdLoad = 0;
  localparam int unsigned CmdPush = 1;

  localparam logic [1:0] RegErrorLimit    = 2'd0;
  localparam logic [1:0] RegEndErrorLimit = 2'd1;
  localparam logic [1:0] RegFirstPosition = 2'd2;
  localparam logic [1:0] RegEndPosition   = 2'd3;

  typedef struct packed {
    logic [TotalW-1:0] error_limit;
    logic [31:0]       end_error_limit;
    logic [PosW-1:0]   first_position;
    logic [PosW-1:0]   end_position;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0]          position;
    logic [TotalW-1:0]        total_error;
    logic [31:0]              end_error;
    logic signed [ValueW-1:0] scale;
    logic signed [ValueW-1:0] offset;
    logic                     matched;
    logic                     flat_pattern;
  } result_t;

  typedef struct packed {
    logic                     start;
    logic signed [ValueW+16:0] num;
    logic signed [ValueW:0]   den;
  } div_req_t;
endpackage

// ===== src/swpm_if.sv =====
// Channel interfaces: input item and result item with valid/ready handshake.
interface swpm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [3:0]                         entry_index;
  logic signed [swpm_pkg::ValueW-1:0] value;
  modport source (output valid, cmd, entry_index, value, input ready);
  modport sink (input valid, cmd, entry_index, value, output ready);
endinterface

interface swpm_out_if;
  logic                               valid;
  logic                               ready;
  logic [swpm_pkg::PosW-1:0]          position;
  logic [swpm_pkg::TotalW-1:0]        total_error;
  logic [31:0]                        end_error;
  logic signed [swpm_pkg::ValueW-1:0] scale;
  logic signed [swpm_pkg::ValueW-1:0] offset;
  logic                               matched;
  logic                               flat_pattern;
  modport source (output valid, position, total_error, end_error, scale, offset, matched,
                  flat_pattern, input ready);
  modport sink (input valid, position, total_error, end_error, scale, offset, matched,
                flat_pattern, output ready);
endinterface

// ===== src/swpm_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating and saturating to 32 bits.
module swpm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swpm_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic signed [31:0]  quot_o
);
  import swpm_pkg::*;
  localparam int unsigned NW = ValueW + 17;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   rem_q, rem_d, quo_q, quo_d;
  logic [ValueW:0] den_q;
  logic            neg_q, busy_q;
  logic [CntW-1:0] cnt_q;
  logic [NW-1:0]   trial;
  logic            fits;
  logic [NW-1:0]   mag;
  logic signed [NW:0] sq;

  always_comb begin
    trial = {rem_q[NW-2:0], quo_q[NW-1]};
    fits  = trial >= NW'(den_q);
    rem_d = fits ? trial - NW'(den_q) : trial;
    quo_d = {quo_q[NW-2:0], fits};
    sq    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    if (sq > 2147483647) begin
      quot_o = 32'sh7fffffff;
    end else if (sq < -(NW+1)'(64'sd2147483648)) begin
      quot_o = 32'sh80000000;
    end else begin
      quot_o = sq[31:0];
    end
    mag = req_i.num[NW-1] ? NW'(-req_i.num) : NW'(req_i.num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
        rem_q  <= '0;
        quo_q  <= mag;
        den_q  <= req_i.den[ValueW] ? -req_i.den : req_i.den;
        neg_q  <= req_i.num[NW-1] ^ req_i.den[ValueW];
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/swpm_core.sv =====
// Sequencer: pattern and ring memories, divide, then one fit point per step; a flat pattern skips divide and fit.
module swpm_core #(
  parameter int unsigned PatternLen = swpm_pkg::PatternLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swpm_pkg::cfg_t    cfg_i,
  swpm_in_if.sink           in_if,
  swpm_out_if.source        out_if
);
  import swpm_pkg::*;
  localparam int unsigned AW = $clog2(PatternLen);
  localparam int unsigned JW = $clog2(PatternLen + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD01, S_RD1, S_CAP1, S_DIV, S_RD, S_MUL, S_ACC, S_OUT
  } state_e;

  state_e state_q;
  logic signed [31:0] pat_mem [PatternLen];
  logic signed [31:0] ring_mem [PatternLen];
  logic signed [31:0] pat_rd_q, ring_rd_q;
  logic [AW-1:0] pat_ra, ring_ra;
  logic [AW-1:0] ptr_q;
  logic [PosW-1:0] seen_q, pos_q;
  logic signed [31:0] p0_q, g0_q, p1_q, g1_q;
  logic signed [31:0] scale_q;
  logic [JW-1:0] j_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] g_q;
  logic [TotalW:0] total_q;
  logic [32:0] last_q;
  logic ring_wr, pat_wr;
  div_req_t div_req;
  logic div_done;
  logic signed [31:0] div_quot;
  logic [PosW-1:0] seen_inc, pos_new;
  logic signed [48:0] diff, err;
  logic [48:0] aerr;
  logic [49:0] tsum;
  logic signed [32:0] offs;
  result_t res_q;
  logic out_v_q;
  logic acc;

  assign acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && !out_v_q;
  assign ring_wr = acc && (in_if.cmd == 1'(CmdPush));
  assign pat_wr = acc && (in_if.cmd == 1'(CmdLoad)) && (32'(in_if.entry_index) < PatternLen);
  assign seen_inc = seen_q + 1'b1;
  assign pos_new = seen_inc - PosW'(PatternLen);

  always_ff @(posedge clk_i) begin
    if (ring_wr) ring_mem[ptr_q] <= in_if.value;
    if (pat_wr) pat_mem[AW'(in_if.entry_index)] <= in_if.value;
    pat_rd_q  <= pat_mem[pat_ra];
    ring_rd_q <= ring_mem[ring_ra];
  end

  // in S_CAP1 the read registers hold the second points
  always_comb begin
    pat_ra  = j_q[AW-1:0];
    ring_ra = AW'((JW+1)'(ptr_q) + (JW+1)'(j_q));
    if (PatternLen == (1 << AW)) ring_ra = ptr_q + j_q[AW-1:0];
    else if ((JW+1)'(ptr_q) + (JW+1)'(j_q) >= (JW+1)'(PatternLen))
      ring_ra = AW'((JW+1)'(ptr_q) + (JW+1)'(j_q) - (JW+1)'(PatternLen));
    div_req.start = (state_q == S_CAP1);
    div_req.num = {{1{ring_rd_q[31]}}, ring_rd_q, 16'd0} - {{1{g0_q[31]}}, g0_q, 16'd0};
    div_req.den = 33'(pat_rd_q) - 33'(p0_q);
    diff = 49'(prod_q >>> 16) + 49'(g0_q) - 49'(g_q);
    err  = diff;
    aerr = err[48] ? 49'(-err) : 49'(err);
    tsum = 50'(total_q) + 50'(aerr);
    offs = 33'(g0_q) - 33'(p0_q);
  end

  swpm_div u_div (.clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quot_o(div_quot));

  assign out_if.valid = out_v_q;
  assign out_if.position = res_q.position;
  assign out_if.total_error = res_q.total_error;
  assign out_if.end_error = res_q.end_error;
  assign out_if.scale = res_q.scale;
  assign out_if.offset = res_q.offset;
  assign out_if.matched = res_q.matched;
  assign out_if.flat_pattern = res_q.flat_pattern;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      seen_q  <= '0;
      out_v_q <= 1'b0;
      j_q     <= '0;
    end else begin
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          j_q <= '0;
          if (ring_wr) begin
            ptr_q  <= (32'(ptr_q) == PatternLen - 1) ? '0 : ptr_q + 1'b1;
            seen_q <= seen_inc;
            pos_q  <= pos_new;
            if (seen_inc >= PosW'(PatternLen) && pos_new >= cfg_i.first_position
                && pos_new < cfg_i.end_position) state_q <= S_RD01;
          end
        end
        S_RD01: begin
          j_q <= JW'(1);
          state_q <= S_RD1;
        end
        S_RD1: begin
          p0_q <= pat_rd_q;
          g0_q <= ring_rd_q;
          state_q <= S_CAP1;
        end
        S_CAP1: begin
          p1_q <= pat_rd_q;
          g1_q <= ring_rd_q;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (p1_q == p0_q) begin
            res_q <= '{position: pos_q, total_error: '0, end_error: '0, scale: '0,
                       offset: (offs > 33'sd2147483647) ? 32'sh7fffffff :
                               (offs < -33'sd2147483648) ? 32'sh80000000 : offs[31:0],
                       matched: 1'b0, flat_pattern: 1'b1};
            state_q <= S_OUT;
          end else if (div_done) begin
            scale_q <= div_quot;
            j_q <= '0;
            total_q <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          prod_q <= scale_q * (64'(pat_rd_q) - 64'(p0_q));
          g_q <= ring_rd_q;
          state_q <= S_ACC;
        end
        S_ACC: begin
          total_q <= (tsum[49:TotalW] != '0) ? {1'b0, {TotalW{1'b1}}} : tsum[TotalW:0];
          last_q <= (aerr[48:32] != '0) ? {1'b0, 32'hffffffff} : aerr[32:0];
          if (32'(j_q) == PatternLen - 1) begin
            state_q <= S_OUT;
            res_q.position <= pos_q;
            res_q.scale <= scale_q;
            res_q.offset <= (offs > 33'sd2147483647) ? 32'sh7fffffff :
                            (offs < -33'sd2147483648) ? 32'sh80000000 : offs[31:0];
            res_q.flat_pattern <= 1'b0;
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_OUT: begin
          if (!res_q.flat_pattern) begin
            res_q.total_error <= total_q[TotalW-1:0];
            res_q.end_error <= last_q[31:0];
            res_q.matched <= (total_q[TotalW-1:0] < cfg_i.error_limit) &&
                             (last_q[31:0] < cfg_i.end_error_limit);
          end
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/swpm_regs.sv =====
// APB register bank holding limits and position window.
module swpm_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output swpm_pkg::cfg_t      cfg_o
);
  import swpm_pkg::*;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_o <= '{error_limit: '0, end_error_limit: '0, first_position: '0,
                 end_position: '1};
    end else if (wr) begin
      case (paddr[4:3])
        RegErrorLimit:    cfg_o.error_limit <= pwdata[TotalW-1:0];
        RegEndErrorLimit: cfg_o.end_error_limit <= pwdata[31:0];
        RegFirstPosition: cfg_o.first_position <= pwdata[PosW-1:0];
        RegEndPosition:   cfg_o.end_position <= pwdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegErrorLimit:    prdata = 64'(cfg_o.error_limit);
      RegEndErrorLimit: prdata = 64'(cfg_o.end_error_limit);
      RegFirstPosition: prdata = 64'(cfg_o.first_position);
      RegEndPosition:   prdata = 64'(cfg_o.end_position);
      default:          prdata = '0;
    endcase
  end
endmodule

// ===== src/scaled_window_pattern_matcher.sv =====
// Top level of the scaled window pattern matcher.
// Usage:
//   in_if carries cmd, entry_index and value. cmd 0 loads a pattern entry,
//   cmd 1 pushes a sample into the ring. A transaction takes place when
//   valid and ready are both high at a rising edge.
//   out_if carries one result per reported window.
//   Registers sit on an APB port at 8-byte spacing (64-bit data).
// Sequence:
//   A pattern load or a silent push takes effect at its transaction. A
//   reporting push reads the first two points, runs the 49-step bit-serial
//   divide, then reads, multiplies and accumulates each pattern point in
//   turn through each memory's single read port and the multiplier, and
//   closes the result. A flat pattern skips the divide and the fit.
//   Ready returns in the cycle after the result is taken.
// Reset: rst_ni clears the ring pointer, sample count and limit and first
//   position registers, sets end_position to all ones; both memories hold garbage until written.
// Stall: while a result waits to be taken, ready stays low.
module scaled_window_pattern_matcher #(
  parameter int unsigned PatternLen = swpm_pkg::PatternLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  swpm_in_if.sink     in_if,
  swpm_out_if.source  out_if
);
  import swpm_pkg::*;
  cfg_t cfg;

  swpm_regs u_regs (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                    .prdata, .pready, .cfg_o(cfg));

  swpm_core #(.PatternLen(PatternLen)) u_core (.clk_i, .rst_ni, .cfg_i(cfg), .in_if,
                                               .out_if);
endmodule
